// File: src/lifn_pkg.sv
// Shared types and constants of the LIF neuron update block.
`timescale 1ns / 1ps
package lifn_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 15;
  localparam int ADDR_W    = 5;

  // shared arithmetic unit operations
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_ADD = 2'd0;
  localparam alu_op_t ALU_SUB = 2'd1;
  localparam alu_op_t ALU_MUL = 2'd2;

  // configuration register indexes
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_REST      = 3'd0;
  localparam reg_idx_t REG_RESET     = 3'd1;
  localparam reg_idx_t REG_OFFSET    = 3'd2;
  localparam reg_idx_t REG_RESIST    = 3'd3;
  localparam reg_idx_t REG_DECAY     = 3'd4;
  localparam reg_idx_t REG_REFRACT   = 3'd5;
  localparam reg_idx_t REG_EXC_COUNT = 3'd6;
  localparam reg_idx_t REG_INH_COUNT = 3'd7;

  typedef struct packed {
    logic signed [31:0] rest_voltage;
    logic signed [31:0] reset_voltage;
    logic signed [31:0] offset_current;
    logic signed [31:0] membrane_resistance;
    logic [15:0]        decay_factor;
    logic [15:0]        refractory_steps;
    logic [1:0]         exc_count;
    logic [1:0]         inh_count;
  } lifn_cfg_t;

endpackage

// File: src/lifn_alu.sv
// Shared saturating add, subtract and fixed-point multiply unit.
`timescale 1ns / 1ps
module lifn_alu (
  input  lifn_pkg::alu_op_t   op,
  input  logic signed [32:0]  a,
  input  logic signed [32:0]  b,
  output logic signed [31:0]  result
);
  import lifn_pkg::*;

  logic signed [33:0] sum;
  logic signed [33:0] dif;
  logic signed [65:0] prod;
  logic signed [65:0] wide;
  logic               in_range;

  assign sum  = {a[32], a} + {b[32], b};
  assign dif  = {a[32], a} - {b[32], b};
  assign prod = a * b;

  always_comb begin
    case (op)
      ALU_ADD: wide = {{32{sum[33]}}, sum};
      ALU_SUB: wide = {{32{dif[33]}}, dif};
      ALU_MUL: wide = prod >>> FRAC_BITS;  // floor toward minus infinity
      default: wide = '0;
    endcase
  end

  // saturate to the signed 32-bit range
  assign in_range = (&wide[65:31]) || (~|wide[65:31]);
  assign result   = in_range ? wide[31:0]
                  : (wide[65] ? 32'sh8000_0000 : 32'sh7fff_ffff);

endmodule

// File: src/lifn_regs.sv
// APB-style configuration register file of the LIF neuron update block.
`timescale 1ns / 1ps
module lifn_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lifn_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output lifn_pkg::lifn_cfg_t       cfg
);
  import lifn_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rest_voltage        <= '0;
      cfg.reset_voltage       <= '0;
      cfg.offset_current      <= '0;
      cfg.membrane_resistance <= '0;
      cfg.decay_factor        <= '0;
      cfg.refractory_steps    <= '0;
      cfg.exc_count           <= 2'd2;
      cfg.inh_count           <= 2'd2;
    end else if (wr) begin
      case (idx)
        REG_REST:      cfg.rest_voltage        <= pwdata;
        REG_RESET:     cfg.reset_voltage       <= pwdata;
        REG_OFFSET:    cfg.offset_current      <= pwdata;
        REG_RESIST:    cfg.membrane_resistance <= pwdata;
        REG_DECAY:     cfg.decay_factor        <= pwdata[15:0];
        REG_REFRACT:   cfg.refractory_steps    <= pwdata[15:0];
        REG_EXC_COUNT: cfg.exc_count           <= pwdata[1:0];
        REG_INH_COUNT: cfg.inh_count           <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REST:      prdata = cfg.rest_voltage;
      REG_RESET:     prdata = cfg.reset_voltage;
      REG_OFFSET:    prdata = cfg.offset_current;
      REG_RESIST:    prdata = cfg.membrane_resistance;
      REG_DECAY:     prdata = {16'd0, cfg.decay_factor};
      REG_REFRACT:   prdata = {16'd0, cfg.refractory_steps};
      REG_EXC_COUNT: prdata = {30'd0, cfg.exc_count};
      REG_INH_COUNT: prdata = {30'd0, cfg.inh_count};
      default:       prdata = '0;
    endcase
  end

endmodule

// File: src/lif_neuron_update_top.sv
// Top level of the LIF neuron update block: sequencer, state and output register.
`timescale 1ns / 1ps
// Leaky integrate-and-fire neuron, s16.15 fixed point, one neuron.
// Input channel (in_valid / in_stall): one request per timestep or spike.
//   opcode 0 integrates the input currents unless the refractory countdown
//   is running, in which case the countdown steps down by one.
//   opcode 1 loads the reset voltage and the refractory period.
// Output channel (out_valid / out_stall): one voltage per request.
// Configuration: APB-style port, registers at byte address 4*index,
//   pready always high; write only while no request is in flight.
// Schedule: an integrating request runs a 10-step schedule on one shared
//   saturating add / multiply unit, then the done state loads the output
//   register. Spike and refractory requests go from idle straight to the
//   done state, which loads the output register. No new request is taken
//   before the current one finishes, since in_stall is high until the
//   sequencer is back in idle.
// Output stall: the output register holds its voltage; a finished request
//   waits in the load cycle until the register frees, then input reopens.
// Reset: membrane and countdown clear to zero, config takes reset values.
module lif_neuron_update_top #(
  parameter int NUM_EXC = 2,
  parameter int NUM_INH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic signed [31:0]            exc_first,
  input  logic signed [31:0]            exc_second,
  input  logic signed [31:0]            inh_first,
  input  logic signed [31:0]            inh_second,
  input  logic signed [31:0]            bias_current,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            voltage,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lifn_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lifn_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EXC   = 4'd1;
  localparam logic [3:0] ST_INH   = 4'd2;
  localparam logic [3:0] ST_CUR   = 4'd3;
  localparam logic [3:0] ST_BIAS  = 4'd4;
  localparam logic [3:0] ST_OFS   = 4'd5;
  localparam logic [3:0] ST_MULR  = 4'd6;
  localparam logic [3:0] ST_ALPHA = 4'd7;
  localparam logic [3:0] ST_DIFF  = 4'd8;
  localparam logic [3:0] ST_MULD  = 4'd9;
  localparam logic [3:0] ST_VOLT  = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  // a second field is summed only if the design carries at least two
  localparam logic EXC_TWO = (NUM_EXC >= 2);
  localparam logic INH_TWO = (NUM_INH >= 2);

  lifn_cfg_t          cfg;
  logic [3:0]         state;
  logic signed [31:0] membrane;
  logic [15:0]        refractory_left;
  logic signed [31:0] acc;
  logic signed [31:0] tmp;
  logic signed [31:0] hold_exc_first;
  logic signed [31:0] hold_exc_second;
  logic signed [31:0] hold_inh_first;
  logic signed [31:0] hold_inh_second;
  logic signed [31:0] hold_bias;

  alu_op_t            alu_op;
  logic signed [32:0] alu_a;
  logic signed [32:0] alu_b;
  logic signed [31:0] alu_y;

  logic               accept;
  logic               out_free;
  logic               exc_en0, exc_en1, inh_en0, inh_en1;

  lifn_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lifn_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_y)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign exc_en0 = (cfg.exc_count != 2'd0);
  assign exc_en1 = cfg.exc_count[1] && EXC_TWO;
  assign inh_en0 = (cfg.inh_count != 2'd0);
  assign inh_en1 = cfg.inh_count[1] && INH_TWO;

  // operand selection for the shared unit
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      ST_EXC: begin
        alu_a = exc_en0 ? {hold_exc_first[31], hold_exc_first} : 33'sd0;
        alu_b = exc_en1 ? {hold_exc_second[31], hold_exc_second} : 33'sd0;
      end
      ST_INH: begin
        alu_a = inh_en0 ? {hold_inh_first[31], hold_inh_first} : 33'sd0;
        alu_b = inh_en1 ? {hold_inh_second[31], hold_inh_second} : 33'sd0;
      end
      ST_CUR: begin
        alu_op = ALU_SUB;
        alu_a  = {acc[31], acc};
        alu_b  = {tmp[31], tmp};
      end
      ST_BIAS: begin
        alu_a = {acc[31], acc};
        alu_b = {hold_bias[31], hold_bias};
      end
      ST_OFS: begin
        alu_a = {acc[31], acc};
        alu_b = {cfg.offset_current[31], cfg.offset_current};
      end
      ST_MULR: begin
        alu_op = ALU_MUL;
        alu_a  = {acc[31], acc};
        alu_b  = {cfg.membrane_resistance[31], cfg.membrane_resistance};
      end
      ST_ALPHA: begin
        alu_a = {acc[31], acc};
        alu_b = {cfg.rest_voltage[31], cfg.rest_voltage};
      end
      ST_DIFF: begin
        alu_op = ALU_SUB;
        alu_a  = {acc[31], acc};
        alu_b  = {membrane[31], membrane};
      end
      ST_MULD: begin
        alu_op = ALU_MUL;
        alu_a  = {17'd0, cfg.decay_factor};
        alu_b  = {tmp[31], tmp};
      end
      ST_VOLT: begin
        alu_op = ALU_SUB;
        alu_a  = {acc[31], acc};
        alu_b  = {tmp[31], tmp};
      end
      default: ;
    endcase
  end

  // capture the request fields on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_exc_first  <= exc_first;
      hold_exc_second <= exc_second;
      hold_inh_first  <= inh_first;
      hold_inh_second <= inh_second;
      hold_bias       <= bias_current;
    end
  end

  // working registers of the schedule
  always_ff @(posedge clk) begin
    case (state)
      ST_EXC, ST_CUR, ST_BIAS, ST_OFS, ST_MULR, ST_ALPHA: acc <= alu_y;
      ST_INH, ST_DIFF, ST_MULD:                           tmp <= alu_y;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      membrane        <= '0;
      refractory_left <= '0;
      out_valid       <= 1'b0;
    end else begin
      // drop valid once taken, unless a new voltage loads in the same cycle
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (opcode) begin
              membrane        <= cfg.reset_voltage;
              refractory_left <= cfg.refractory_steps;
              state           <= ST_DONE;
            end else if (refractory_left != 16'd0) begin
              refractory_left <= refractory_left - 16'd1;
              state           <= ST_DONE;
            end else begin
              state <= ST_EXC;
            end
          end
        end
        ST_VOLT: begin
          membrane <= alu_y;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= state + 4'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      voltage <= membrane;
    end
  end

endmodule

// File: sim/lif_neuron_update_top_tb.sv
// Self-checking testbench for the LIF neuron update block, with its own voltage predictor.
`timescale 1ns / 1ps
module lif_neuron_update_top_tb;
  import lifn_pkg::*;

  localparam int NUM_EXC = 2;
  localparam int NUM_INH = 2;
  // Quiet cycles (nothing accepted anywhere) before the run is declared hung.
  localparam int HANG_LIMIT = 4000;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_REQS = 112;
  localparam int DRAIN_CYCLES = 16;

  typedef bit neuron_op_t;
  localparam neuron_op_t OP_STEP  = 1'b0;
  localparam neuron_op_t OP_SPIKE = 1'b1;

  // One request as it goes onto the input channel; known marks a row whose
  // voltage is typed into the directed table.
  typedef struct {
    int unsigned        tag;
    neuron_op_t         opcode;
    logic signed [31:0] exc_first;
    logic signed [31:0] exc_second;
    logic signed [31:0] inh_first;
    logic signed [31:0] inh_second;
    logic signed [31:0] bias_current;
    bit                 known;
    logic [31:0]        known_volt;
  } neuron_req_t;

  typedef struct {
    bit          is_reg;
    reg_idx_t    idx;
    logic [31:0] value;
    neuron_req_t req;
  } plan_row_t;

  typedef struct {
    int unsigned tag;
    logic [31:0] volt;
  } volt_expect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic signed [31:0] exc_first = '0;
  logic signed [31:0] exc_second = '0;
  logic signed [31:0] inh_first = '0;
  logic signed [31:0] inh_second = '0;
  logic signed [31:0] bias_current = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] voltage;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lif_neuron_update_top #(
    .NUM_EXC(NUM_EXC),
    .NUM_INH(NUM_INH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .exc_first(exc_first),
    .exc_second(exc_second),
    .inh_first(inh_first),
    .inh_second(inh_second),
    .bias_current(bias_current),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .voltage(voltage),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // Predictor state: shadow of the register file plus the neuron itself.
  lifn_cfg_t          cfg_shadow;
  logic signed [31:0] membrane_v;
  logic [15:0]        refract_left;

  neuron_req_t  req_q[$];     // requests waiting to go onto the input channel
  volt_expect_t volt_q[$];    // voltages owed by the block, oldest first
  neuron_req_t  on_port;      // request currently driven on the input channel
  logic [31:0]  predicted_v;
  volt_expect_t head;
  int unsigned  next_tag = 0;
  int unsigned  error_count = 0;
  int unsigned  send_idle_pct = 35;
  int unsigned  recv_idle_pct = 77;
  int unsigned  quiet_cycles = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // s16.15 product: exact, floored by dropping the 15 fraction bits, saturated.
  function automatic longint mul_q15(longint a, longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> FRAC_BITS);
  endfunction

  // Advance the neuron by one request and return the voltage it leaves behind.
  function automatic logic [31:0] apply_request(neuron_req_t r);
    longint exc_sum, inh_sum, cur, alpha, diff;
    int n_exc, n_inh;
    if (r.opcode == OP_SPIKE) begin
      membrane_v = cfg_shadow.reset_voltage;
      refract_left = cfg_shadow.refractory_steps;
    end else if (refract_left != 16'd0) begin
      refract_left = refract_left - 16'd1;
    end else begin
      // a count past the number of fields sums every field there is
      n_exc = int'(cfg_shadow.exc_count);
      if (n_exc > NUM_EXC) n_exc = NUM_EXC;
      if (n_exc > 2) n_exc = 2;
      n_inh = int'(cfg_shadow.inh_count);
      if (n_inh > NUM_INH) n_inh = NUM_INH;
      if (n_inh > 2) n_inh = 2;
      exc_sum = 0;
      inh_sum = 0;
      if (n_exc > 0) exc_sum = clamp32(exc_sum + longint'(r.exc_first));
      if (n_exc > 1) exc_sum = clamp32(exc_sum + longint'(r.exc_second));
      if (n_inh > 0) inh_sum = clamp32(inh_sum + longint'(r.inh_first));
      if (n_inh > 1) inh_sum = clamp32(inh_sum + longint'(r.inh_second));
      cur = clamp32(exc_sum - inh_sum);
      cur = clamp32(cur + longint'(r.bias_current));
      cur = clamp32(cur + longint'($signed(cfg_shadow.offset_current)));
      alpha = clamp32(mul_q15(cur, longint'($signed(cfg_shadow.membrane_resistance)))
                      + longint'($signed(cfg_shadow.rest_voltage)));
      diff = clamp32(alpha - longint'(membrane_v));
      // decay is unsigned and may exceed one; the result still saturates
      membrane_v = 32'(clamp32(alpha - mul_q15(longint'(cfg_shadow.decay_factor), diff)));
    end
    return membrane_v;
  endfunction

  task automatic report_mismatch(string what, int unsigned tag, logic [31:0] got,
                                 logic [31:0] want);
    $display("MISMATCH request %0d: %s got %h want %h", tag, what, got, want);
    error_count++;
  endtask

  // Mostly small s16.15 values, some full-width words, some extremes.
  function automatic logic [31:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
    if (pick < 85) return $urandom;
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic plan_row_t reg_row(reg_idx_t idx, logic [31:0] value);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.idx = idx;
    row.value = value;
    return row;
  endfunction

  function automatic plan_row_t req_row(neuron_op_t op, logic [31:0] e1, logic [31:0] e2,
                                        logic [31:0] i1, logic [31:0] i2, logic [31:0] b,
                                        bit known, logic [31:0] kv);
    plan_row_t row;
    row = '{default: '0};
    row.req.opcode = op;
    row.req.exc_first = e1;
    row.req.exc_second = e2;
    row.req.inh_first = i1;
    row.req.inh_second = i2;
    row.req.bias_current = b;
    row.req.known = known;
    row.req.known_volt = kv;
    return row;
  endfunction

  // Queue one request for the input channel, tagging it for messages.
  task automatic queue_request(neuron_req_t r);
    r.tag = next_tag;
    next_tag++;
    req_q.push_back(r);
  endtask

  // Hold until the input side is empty and every owed voltage has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (req_q.size() != 0 || in_valid || volt_q.size() != 0) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where psel, penable, pwrite and pready are all high.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_REST:      cfg_shadow.rest_voltage = value;
      REG_RESET:     cfg_shadow.reset_voltage = value;
      REG_OFFSET:    cfg_shadow.offset_current = value;
      REG_RESIST:    cfg_shadow.membrane_resistance = value;
      REG_DECAY:     cfg_shadow.decay_factor = value[15:0];
      REG_REFRACT:   cfg_shadow.refractory_steps = value[15:0];
      REG_EXC_COUNT: cfg_shadow.exc_count = value[1:0];
      default:       cfg_shadow.inh_count = value[1:0];
    endcase
  endtask

  // Input channel driver. Predict each request at the edge that accepts it,
  // then either present the next one or drop valid for a random idle cycle.
  // A presented request stays on the port untouched until it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_v = apply_request(on_port);
        if (on_port.known) predicted_v = on_port.known_volt;
        volt_q.push_back('{tag: on_port.tag, volt: predicted_v});
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_port = req_q.pop_front();
          in_valid <= 1'b1;
          opcode <= on_port.opcode;
          exc_first <= on_port.exc_first;
          exc_second <= on_port.exc_second;
          inh_first <= on_port.inh_first;
          inh_second <= on_port.inh_second;
          bias_current <= on_port.bias_current;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: stall at random, at whatever rate the current phase asks.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare every accepted voltage with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (volt_q.size() == 0) begin
        report_mismatch("voltage with nothing owed", 0, voltage, 32'h0);
      end else begin
        head = volt_q.pop_front();
        if (voltage !== head.volt) report_mismatch("voltage", head.tag, voltage, head.volt);
      end
    end
  end

  // Count cycles in which neither channel nor the register port moves.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < HANG_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main_seq
    plan_row_t   plan[$];
    neuron_req_t r;
    int          phase;
    int          n;

    cfg_shadow = '0;
    cfg_shadow.exc_count = 2'd2;
    cfg_shadow.inh_count = 2'd2;
    membrane_v = '0;
    refract_left = '0;

    // Directed table. Typed voltages only where they are obvious: reset
    // state, saturation at the rails, spike loads and held countdowns.
    // Reset values: zero resistance and zero decay pin the voltage at rest.
    plan.push_back(req_row(OP_STEP, 0, 0, 0, 0, 0, 1, 32'h0000_0000));
    plan.push_back(req_row(OP_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h0000_0000));
    // spike ignores its current fields
    plan.push_back(req_row(OP_SPIKE, 32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_FFFF,
                           32'h8000_0001, 32'h5555_AAAA, 1, 32'h0000_0000));
    // unit resistance, no decay: the voltage follows the current
    plan.push_back(reg_row(REG_RESIST, 32'h0000_8000));
    plan.push_back(req_row(OP_STEP, 32'h0032_0000, 32'h0064_0000, 32'h0019_0000,
                           32'h000C_8000, 32'h0002_8000, 0, 0));
    plan.push_back(req_row(OP_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF));
    plan.push_back(req_row(OP_STEP, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h8000_0000));
    // excitatory count past the number of fields, then counts of zero and one
    plan.push_back(reg_row(REG_EXC_COUNT, 32'd3));
    plan.push_back(req_row(OP_STEP, 32'h0000_03E8, 32'h0000_07D0, 0, 0, 0, 0, 0));
    plan.push_back(reg_row(REG_EXC_COUNT, 32'd0));
    plan.push_back(reg_row(REG_INH_COUNT, 32'd1));
    plan.push_back(req_row(OP_STEP, 32'h0000_03E8, 32'h0000_07D0, 32'h0000_012C,
                           32'h0000_0190, 32'h0000_0007, 0, 0));
    // decay above one, then exactly one
    plan.push_back(reg_row(REG_EXC_COUNT, 32'd2));
    plan.push_back(reg_row(REG_DECAY, 32'h0000_FFFF));
    plan.push_back(reg_row(REG_REST, 32'hFFF0_0000));
    plan.push_back(req_row(OP_STEP, 32'h0001_0000, 32'h0000_4000, 32'h0000_2000,
                           32'h0000_1000, 32'hFFFF_8000, 0, 0));
    plan.push_back(req_row(OP_STEP, 32'h0003_0000, 32'h0000_0001, 32'h0000_0000,
                           32'h0000_1000, 32'h0000_8000, 0, 0));
    plan.push_back(reg_row(REG_DECAY, 32'h0000_8000));
    plan.push_back(req_row(OP_STEP, 32'h0100_0000, 32'h0000_0000, 32'h0000_0000,
                           32'h0000_0000, 32'h0000_0000, 0, 0));
    // spike with a short refractory period: the voltage holds while counting
    plan.push_back(reg_row(REG_RESET, 32'h8000_0000));
    plan.push_back(reg_row(REG_REFRACT, 32'd3));
    plan.push_back(req_row(OP_SPIKE, 0, 0, 0, 0, 0, 1, 32'h8000_0000));
    plan.push_back(req_row(OP_STEP, 32'h0010_0000, 0, 0, 0, 0, 1, 32'h8000_0000));
    plan.push_back(req_row(OP_STEP, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, 32'h8000_0000));
    plan.push_back(req_row(OP_STEP, 32'h8000_0000, 0, 0, 0, 0, 1, 32'h8000_0000));
    plan.push_back(req_row(OP_STEP, 32'h0010_0000, 32'h0001_0000, 0, 0, 0, 0, 0));
    // longest refractory period, then a spike with none: countdown stays at zero
    plan.push_back(reg_row(REG_REFRACT, 32'h0000_FFFF));
    plan.push_back(reg_row(REG_RESET, 32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_OFFSET, 32'h7FFF_FFFF));
    plan.push_back(req_row(OP_SPIKE, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF));
    plan.push_back(req_row(OP_STEP, 32'h8000_0000, 0, 0, 0, 0, 1, 32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_REFRACT, 32'd0));
    plan.push_back(req_row(OP_SPIKE, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF));
    plan.push_back(req_row(OP_STEP, 32'h0000_1000, 32'hFFFF_0000, 32'h0002_0000,
                           32'h0000_0001, 32'h0000_0000, 0, 0));
    // most negative resistance and offset against the top resting level
    plan.push_back(reg_row(REG_OFFSET, 32'h8000_0000));
    plan.push_back(reg_row(REG_RESIST, 32'h8000_0000));
    plan.push_back(reg_row(REG_DECAY, 32'd0));
    plan.push_back(reg_row(REG_REST, 32'h7FFF_FFFF));
    plan.push_back(req_row(OP_STEP, 32'h0000_0100, 32'h0000_0200, 0, 0, 0, 0, 0));
    plan.push_back(req_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0));

    // Hold reset at the start, once, then release it.
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the table; drain before every register write.
    send_idle_pct = 35;
    recv_idle_pct = 77;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        queue_request(plan[i].req);
      end
    end

    // Random phases: three idling modes, three register settings each.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      wait_drained();
      case (phase / 3)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(REG_REST, rand_word());
      write_reg(REG_RESET, rand_word());
      write_reg(REG_OFFSET, rand_word());
      write_reg(REG_RESIST, rand_word());
      case ($urandom_range(9))
        0: write_reg(REG_DECAY, 32'd0);
        1: write_reg(REG_DECAY, 32'h0000_8000);
        2: write_reg(REG_DECAY, 32'h0000_FFFF);
        3: write_reg(REG_DECAY, $urandom);
        default: write_reg(REG_DECAY, $urandom_range(32'h0000_8000));
      endcase
      case ($urandom_range(9))
        0: write_reg(REG_REFRACT, 32'h0000_FFFF);
        1, 2: write_reg(REG_REFRACT, $urandom_range(20, 5));
        default: write_reg(REG_REFRACT, $urandom_range(4));
      endcase
      write_reg(REG_EXC_COUNT, $urandom_range(3));
      write_reg(REG_INH_COUNT, $urandom_range(3));
      // Mostly timesteps with occasional spikes, so countdowns start and run out.
      for (n = 0; n < PHASE_REQS; n++) begin
        r = '{default: '0};
        r.opcode = ($urandom_range(99) < 12) ? OP_SPIKE : OP_STEP;
        r.exc_first = rand_word();
        r.exc_second = rand_word();
        r.inh_first = rand_word();
        r.inh_second = rand_word();
        r.bias_current = rand_word();
        queue_request(r);
      end
    end

    // Drain, then give any stray voltage time to show up.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (volt_q.size() != 0) begin
      head = volt_q.pop_front();
      report_mismatch("voltage never arrived", head.tag, 32'h0, head.volt);
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: lif_neuron_update_top.f
src/lifn_pkg.sv
src/lifn_alu.sv
src/lifn_regs.sv
src/lif_neuron_update_top.sv
sim/lif_neuron_update_top_tb.sv
